@@ rtl/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned WordBitsDefault = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_LT  = 4'd4,
    OP_GT  = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_NEG = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_PREP,
    S_SHIFT,
    S_GCD,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic prep;
    logic shift;
    logic gcd;
    logic div_start;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic shift_done;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

@@ rtl/rau_ctrl.sv @@
// control state machine of the rational arithmetic unit
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rau_pkg::cmd_t cmd,
  input  rau_pkg::sts_t sts
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_PREP;
      S_PREP:  state_nxt = sts.early ? S_OUT : S_SHIFT;
      S_SHIFT: if (sts.shift_done) state_nxt = S_GCD;
      S_GCD:   if (sts.gcd_done) state_nxt = S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL1:  cmd.mul1 = 1'b1;
      S_MUL2:  cmd.mul2 = 1'b1;
      S_PREP:  cmd.prep = 1'b1;
      S_SHIFT: begin
        cmd.shift = 1'b1;
        cmd.div_start = sts.shift_done;
      end
      S_GCD: begin
        cmd.gcd = 1'b1;
        cmd.div_start = sts.gcd_done;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.fin = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

@@ rtl/rau_dp.sv @@
// datapath: cross products, binary gcd and restoring division
module rau_dp #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDefault
) (
  input  logic               clk,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_status,
  input  rau_pkg::cmd_t      cmd,
  output rau_pkg::sts_t      sts
);
  import rau_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned P = 2 * W;
  localparam int unsigned CW = $clog2(P + 1);

  function automatic logic [W-1:0] mag(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]   op_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic         as_r, bs_r, adz_r, bdz_r, bnz_r;
  logic [P-1:0] p1_r, p2_r, rn_r, rd_r;
  logic         rs_r;
  logic [P-1:0] x_r, y_r;
  logic [CW-1:0] k_r;
  logic [P-1:0] g_r, q_r, rem_r;
  logic [P-1:0] qn_r;
  logic         phase_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]  res_num_r;
  logic [30:0]  res_den_r;
  logic         cmp_r;
  logic [1:0]   st_r;
  logic         div_fin_r;

  logic [P:0]   big_sum;
  logic         big_sign;
  logic [P-1:0] big_mag;
  logic         sa, sb;
  logic [P:0]   trial;
  logic [P-1:0] xm, ym, lim;
  logic         early_c;

  always_comb begin
    sa = as_r && p1_r != '0;
    sb = bs_r && p2_r != '0;
    big_sum = '0;
    big_sign = 1'b0;
    if (sa == (sb ^ (op_r == OP_SUB))) begin
      big_sum = {1'b0, p1_r} + {1'b0, p2_r};
      big_sign = sa;
    end else if (p1_r >= p2_r) begin
      big_sum = {1'b0, p1_r - p2_r};
      big_sign = sa;
    end else begin
      big_sum = {1'b0, p2_r - p1_r};
      big_sign = ~sa;
    end
    big_mag = big_sum[P-1:0];
  end

  // result is known without gcd and division
  always_comb begin
    early_c = 1'b1;
    if (op_r <= OP_NEG && !adz_r && !(op_r != OP_NEG && bdz_r) &&
        !(op_r == OP_DIV && bnz_r) && !(op_r >= OP_LT && op_r <= OP_NE)) begin
      case (op_r)
        OP_ADD, OP_SUB: early_c = big_mag == '0;
        OP_NEG:         early_c = an_r == '0;
        default:        early_c = rn_r == '0;
      endcase
    end
  end

  assign xm = x_r;
  assign ym = y_r;
  assign lim = P'(1) << (W - 1);
  assign trial = {rem_r, (phase_r ? qn_r[P-1] : rn_r[P-1])} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      an_r  <= mag(in_a_num);
      ad_r  <= mag(in_a_den);
      bn_r  <= mag(in_b_num);
      bd_r  <= mag(in_b_den);
      as_r  <= in_a_num[W-1] ^ in_a_den[W-1];
      bs_r  <= in_b_num[W-1] ^ in_b_den[W-1];
      adz_r <= in_a_den[W-1:0] == '0;
      bdz_r <= in_b_den[W-1:0] == '0;
      bnz_r <= in_b_num[W-1:0] == '0;
    end
    if (cmd.mul1) begin
      p1_r <= P'(an_r) * P'(bd_r);
      p2_r <= P'(bn_r) * P'(ad_r);
    end
    if (cmd.mul2) begin
      rn_r <= (op_r == OP_DIV) ? p1_r : P'(an_r) * P'(bn_r);
      rd_r <= (op_r == OP_DIV) ? P'(ad_r) * P'(bn_r) : P'(ad_r) * P'(bd_r);
    end
    if (cmd.prep) begin
      res_num_r <= '0;
      res_den_r <= 31'd1;
      cmp_r <= 1'b0;
      st_r <= ST_OK;
      if (op_r > OP_NEG) begin
      end else if (adz_r || (op_r != OP_NEG && bdz_r) || (op_r == OP_DIV && bnz_r)) begin
        res_den_r <= '0;
        st_r <= ST_DIVZ;
      end else if (op_r >= OP_LT && op_r <= OP_NE) begin
        case (op_r)
          OP_LT:   cmp_r <= (sa != sb) ? sa : (p1_r != p2_r) && ((p1_r < p2_r) ^ sa);
          OP_GT:   cmp_r <= (sa != sb) ? sb : (p1_r != p2_r) && ((p1_r > p2_r) ^ sa);
          OP_EQ:   cmp_r <= (sa == sb) && (p1_r == p2_r);
          default: cmp_r <= !((sa == sb) && (p1_r == p2_r));
        endcase
      end else begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            rn_r <= big_mag;
            rs_r <= big_sign;
          end
          OP_MUL, OP_DIV: rs_r <= as_r ^ bs_r;
          default: begin
            rn_r <= P'(an_r);
            rd_r <= P'(ad_r);
            rs_r <= ~as_r;
          end
        endcase
        case (op_r)
          OP_ADD, OP_SUB: x_r <= big_mag;
          OP_NEG:         x_r <= P'(an_r);
          default:        x_r <= rn_r;
        endcase
        y_r <= (op_r == OP_NEG) ? P'(ad_r) : rd_r;
        k_r <= '0;
      end
    end
    if (cmd.shift && !sts.shift_done) begin
      x_r <= xm >> 1;
      y_r <= ym >> 1;
      k_r <= k_r + 1'b1;
    end
    if (cmd.gcd && !sts.gcd_done) begin
      if (!xm[0]) x_r <= xm >> 1;
      else if (!ym[0]) y_r <= ym >> 1;
      else if (xm >= ym) x_r <= (xm - ym) >> 1;
      else y_r <= (ym - xm) >> 1;
    end
    if (cmd.div_start) begin
      g_r <= ym << k_r;
      rem_r <= '0;
      cnt_r <= '0;
      phase_r <= 1'b0;
      qn_r <= rd_r;
    end
    if (cmd.div_step && !sts.div_done) begin
      if (!trial[P]) begin
        rem_r <= trial[P-1:0];
      end else begin
        rem_r <= {rem_r[P-2:0], (phase_r ? qn_r[P-1] : rn_r[P-1])};
      end
      if (phase_r) qn_r <= {qn_r[P-2:0], ~trial[P]};
      else rn_r <= {rn_r[P-2:0], ~trial[P]};
      if (cnt_r == CW'(P - 1)) begin
        cnt_r <= '0;
        rem_r <= '0;
        phase_r <= ~phase_r;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.fin) begin
      if (qn_r >= lim || (rs_r ? (rn_r > lim) : (rn_r >= lim))) begin
        res_num_r <= '0;
        res_den_r <= '0;
        st_r <= ST_OVF;
      end else begin
        res_num_r <= 32'(signed'(rs_r ? (P'(0) - rn_r) : rn_r));
        res_den_r <= 31'(qn_r);
        st_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) div_fin_r <= 1'b0;
    else if (cmd.div_step && phase_r && cnt_r == CW'(P - 1)) div_fin_r <= 1'b1;
  end

  assign sts = '{early: early_c,
                 shift_done: xm[0] || ym[0],
                 gcd_done: (xm == '0) || (ym == '0),
                 div_done: div_fin_r};

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_compare_true = cmp_r;
  assign out_status = st_r;
endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// top level of the rational arithmetic unit
// One transaction at a time: cross products in S_MUL1 and S_MUL2, a binary gcd of the
// 2*WORD_BITS-bit numerator and denominator, then two restoring divisions by the gcd,
// numerator then denominator; comparisons, errors, zero results and unknown operations
// skip the gcd and the divisions.
// The result is held on the out_ ports until taken.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .in_operation(in_operation), .in_a_num(in_a_num),
    .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_compare_true(out_compare_true), .out_status(out_status),
    .cmd(cmd), .sts(sts)
  );
endmodule

@@ dv/tb.sv @@
// testbench for the rational arithmetic unit: random and directed operands checked against a predictor
`timescale 1ns / 100ps

module tb;
  import rau_pkg::*;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    logic [1:0]         st;
  } fraction_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_operation;
  logic signed [31:0] in_a_num;
  logic signed [31:0] in_a_den;
  logic signed [31:0] in_b_num;
  logic signed [31:0] in_b_den;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic               out_compare_true;
  logic [1:0]         out_status;

  fraction_result_t expected_results[$];
  int unsigned      error_count;
  int unsigned      hold_off_cycles;

  rational_arithmetic_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
  endfunction

  function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // signed-magnitude sum, magnitudes up to 2^63
  function automatic logic [63:0] sm_sum(input logic sx, input logic [63:0] mx,
                                         input logic sy, input logic [63:0] my,
                                         output logic sr);
    if (sx == sy) begin
      sr = sx;
      return mx + my;
    end
    if (mx >= my) begin
      sr = sx;
      return mx - my;
    end
    sr = sy;
    return my - mx;
  endfunction

  function automatic fraction_result_t predict_fraction(input logic [3:0] op,
      input logic [31:0] an_r, input logic [31:0] ad_r,
      input logic [31:0] bn_r, input logic [31:0] bd_r);
    fraction_result_t r;
    logic [63:0] an, ad, bn, bd, rn, rd, g, lhs, rhs, lim;
    logic as_, bs_, rs, ls, bsn, less_f, eq_f;
    an = magnitude(an_r);
    ad = magnitude(ad_r);
    bn = magnitude(bn_r);
    bd = magnitude(bd_r);
    as_ = an_r[31] ^ ad_r[31];
    bs_ = bn_r[31] ^ bd_r[31];
    rs = 1'b0;
    r = '{num: '0, den: 31'd1, cmp: 1'b0, st: ST_OK};
    if (op > OP_NEG) return r;
    if (ad == 0 || (op != OP_NEG && bd == 0) || (op == OP_DIV && bn == 0)) begin
      r.den = '0;
      r.st = ST_DIVZ;
      return r;
    end
    if (op >= OP_LT && op <= OP_NE) begin
      lhs = an * bd;
      rhs = bn * ad;
      ls = (lhs == 0) ? 1'b0 : as_;
      bsn = (rhs == 0) ? 1'b0 : bs_;
      eq_f = (ls == bsn) && (lhs == rhs);
      if (ls != bsn) less_f = ls;
      else if (!ls) less_f = lhs < rhs;
      else less_f = lhs > rhs;
      case (op)
        OP_LT:   r.cmp = less_f;
        OP_GT:   r.cmp = !less_f && !eq_f;
        OP_EQ:   r.cmp = eq_f;
        default: r.cmp = !eq_f;
      endcase
      return r;
    end
    case (op)
      OP_ADD: begin
        rn = sm_sum(as_, an * bd, bs_, bn * ad, rs);
        rd = ad * bd;
      end
      OP_SUB: begin
        rn = sm_sum(as_, an * bd, !bs_, bn * ad, rs);
        rd = ad * bd;
      end
      OP_MUL: begin
        rn = an * bn;
        rs = as_ ^ bs_;
        rd = ad * bd;
      end
      OP_DIV: begin
        rn = an * bd;
        rs = as_ ^ bs_;
        rd = ad * bn;
      end
      default: begin
        rn = an;
        rs = !as_;
        rd = ad;
      end
    endcase
    if (rn == 0) return r;
    g = gcd_of(rn, rd);
    rn = rn / g;
    rd = rd / g;
    lim = 64'd1 << 31;
    if (rd >= lim || (rs ? (rn > lim) : (rn >= lim))) begin
      r.den = '0;
      r.st = ST_OVF;
      return r;
    end
    r.num = rs ? (32'd0 - rn[31:0]) : rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic send_fraction_op(input logic [3:0] op, input logic [31:0] an,
                                  input logic [31:0] ad, input logic [31:0] bn,
                                  input logic [31:0] bd);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    expected_results.push_back(predict_fraction(op, an, ad, bn, bd));
    in_valid <= 1'b1;
    in_operation <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7fff_ffff - $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 32'd1;
      3: return $urandom_range(0, 1000) - 32'd500;
      4: return $urandom_range(0, 65535) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'd6};
    for (int op = 0; op <= 15; op++)
      send_fraction_op(4'(op), 32'd3, 32'hffff_fffc, 32'd6, 32'd8);
    send_fraction_op(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_fraction_op(OP_NEG, 32'd1, 32'd2, 32'd5, 32'd0);
    send_fraction_op(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
    send_fraction_op(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
    send_fraction_op(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_fraction_op(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'h7fff_ffff);
    send_fraction_op(OP_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    for (int i = 0; i < 6; i++)
      send_fraction_op(OP_DIV, edges[i], edges[5 - i], edges[(i + 2) % 6], edges[i]);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count)
      send_fraction_op(4'($urandom_range(0, 9) == 9 ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 8)),
                       rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 3000;
    test_random(8);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected transaction");
        error_count++;
      end else begin
        fraction_result_t e;
        e = expected_results.pop_front();
        if (out_res_num !== e.num) report_mismatch("res_num", out_res_num, e.num);
        if (out_res_den !== e.den)
          report_mismatch("res_den", 32'(out_res_den), 32'(e.den));
        if (out_compare_true !== e.cmp)
          report_mismatch("compare_true", 32'(out_compare_true), 32'(e.cmp));
        if (out_status !== e.st)
          report_mismatch("status", 32'(out_status), 32'(e.st));
      end
    end
  end

  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    #(1750 * 1200 * 10 * 4);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    error_count = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_a_num = '0;
    in_a_den = '0;
    in_b_num = '0;
    in_b_den = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random(1720);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
